// ----- design/wsd_pkg.sv -----
`default_nettype none

package wsd_pkg;

    // header constants
    localparam logic [3:0] OpcodeMask  = 4'hF;
    localparam logic [3:0] OpcodeClose = 4'h8;
    localparam logic [6:0] LenExt16    = 7'd126;
    localparam logic [6:0] LenExt64    = 7'd127;
    localparam logic [2:0] KeyBytes    = 3'd4;
    localparam logic [15:0] CloseLen   = 16'd2;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXTH = 3'd2,
        PH_EXTL = 3'd3,
        PH_KEY  = 3'd4,
        PH_PAY  = 3'd5,
        PH_DONE = 3'd6,
        PH_REJ  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_CLOSE = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_done;
        t_status     status;
        logic [15:0] decoded_len;
    } t_out_beat;

    // output buffer occupancy, seen by the top level
    typedef struct packed {
        logic out_full;
        logic skid_full;
    } t_buf_status;

endpackage

`default_nettype wire

// ----- design/websocket_frame_deframer.sv -----
`default_nettype none

// WebSocket frame deframer. Takes one received buffer a byte per beat, with
// buffer_end set on its last byte, and parses one frame from it: opcode
// nibble, mask bit, 7-bit length or 16-bit extended length (the 64-bit code
// rejects the frame), and the 4-byte key when masked. Payload bytes come out
// unmasked, one result beat per payload byte; the beat for the last buffer
// byte carries frame_done, status (ok, malformed/incomplete, close) and the
// decoded length. Close frames (opcode 8, length 2) stream no payload. Bytes
// past the frame end make no result unless they end the buffer. Consumers
// drop streamed bytes of a frame whose status is not ok. The parser updates
// its state at accept and the result lands in a two-deep output buffer, so
// one byte per cycle is sustained while the sink takes results; input stall
// rises only when both output slots are full. The parser resets itself after
// every buffer end.
module websocket_frame_deframer (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // input beats
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wsd_pkg::t_in_beat  i_in_data,
    // result beats
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output wsd_pkg::t_out_beat o_out_data
);
    import wsd_pkg::*;

    logic        accept;
    logic        res_valid;
    t_out_beat   res;
    t_buf_status buf_st;

    // stall depends only on buffer occupancy, never on the input valid
    assign o_in_stall = buf_st.skid_full;
    assign accept     = i_in_valid && !o_in_stall;

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_beat      (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (res_valid),
        .i_wr_data   (res),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_status    (buf_st)
    );

    // skid slot fills only behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_st.skid_full |-> buf_st.out_full)
        else $error("skid slot full with output slot empty");

    // a mid-frame beat carries no status and no length
    a_no_status_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.frame_done) |->
        (o_out_data.status == ST_OK && o_out_data.decoded_len == 16'd0
         && o_out_data.payload_valid))
        else $error("result beat without payload or frame end");

    // a close frame ends with no payload byte and length two
    a_close_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_CLOSE) |->
        (!o_out_data.payload_valid && o_out_data.decoded_len == CloseLen))
        else $error("close status on malformed result beat");

endmodule

`default_nettype wire

// ----- design/wsd_parser.sv -----
`default_nettype none

module wsd_parser (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wsd_pkg::t_in_beat    i_beat,
    output logic                 o_res_valid,
    output wsd_pkg::t_out_beat   o_res
);
    import wsd_pkg::*;

    t_phase      r_phase,   n_phase;
    logic [2:0]  r_hcount,  n_hcount;
    logic [3:0]  r_opcode,  n_opcode;
    logic        r_masked,  n_masked;
    logic [15:0] r_plen,    n_plen;
    logic [31:0] r_key,     n_key;
    logic [15:0] r_pcount,  n_pcount;

    logic [7:0]  b;
    logic        last;
    logic [6:0]  len_code;
    logic [7:0]  key_byte;
    logic [7:0]  pb;
    logic        pv;
    logic        is_close;

    assign b        = i_beat.in_byte;
    assign last     = i_beat.buffer_end;
    assign len_code = b[6:0];

    always_comb begin
        case (r_pcount[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_hcount = r_hcount;
        n_opcode = r_opcode;
        n_masked = r_masked;
        n_plen   = r_plen;
        n_key    = r_key;
        n_pcount = r_pcount;
        pv       = 1'b0;
        pb       = b;
        case (r_phase)
            PH_HDR0: begin
                n_opcode = b[3:0] & OpcodeMask;
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                n_masked = b[7];
                if (len_code == LenExt16) begin
                    n_phase = PH_EXTH;
                end else if (len_code == LenExt64) begin
                    n_phase = PH_REJ;
                end else begin
                    n_plen = {9'd0, len_code};
                    if (b[7])
                        n_phase = PH_KEY;
                    else if (len_code == 7'd0)
                        n_phase = PH_DONE;
                    else
                        n_phase = PH_PAY;
                end
            end
            PH_EXTH: begin
                n_plen  = {b, 8'h00};
                n_phase = PH_EXTL;
            end
            PH_EXTL: begin
                n_plen = r_plen | {8'h00, b};
                if (r_masked)
                    n_phase = PH_KEY;
                else if (n_plen == 16'd0)
                    n_phase = PH_DONE;
                else
                    n_phase = PH_PAY;
            end
            PH_KEY: begin
                n_key    = {r_key[23:0], b};
                n_hcount = r_hcount + 3'd1;
                if (n_hcount >= KeyBytes)
                    n_phase = (r_plen == 16'd0) ? PH_DONE : PH_PAY;
            end
            PH_PAY: begin
                pb       = r_masked ? (b ^ key_byte) : b;
                pv       = !((r_plen == CloseLen) && (r_opcode == OpcodeClose));
                n_pcount = r_pcount + 16'd1;
                if (n_pcount == r_plen)
                    n_phase = PH_DONE;
            end
            default: begin
            end
        endcase
    end

    assign is_close = (n_plen == CloseLen) && (n_opcode == OpcodeClose);

    always_comb begin
        o_res_valid          = i_accept && (pv || last);
        o_res.payload_byte   = pv ? pb : 8'h00;
        o_res.payload_valid  = pv;
        o_res.frame_done     = last;
        o_res.status         = ST_OK;
        o_res.decoded_len    = 16'd0;
        if (last) begin
            if (n_phase != PH_DONE)
                o_res.status = ST_BAD;
            else if (is_close)
                o_res.status = ST_CLOSE;
            else
                o_res.status = ST_OK;
            o_res.decoded_len = n_plen;
        end
    end

    // buffer end returns the parser to its reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && last)) begin
            r_phase  <= PH_HDR0;
            r_hcount <= '0;
            r_opcode <= '0;
            r_masked <= 1'b0;
            r_plen   <= '0;
            r_key    <= '0;
            r_pcount <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_hcount <= n_hcount;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_plen   <= n_plen;
            r_key    <= n_key;
            r_pcount <= n_pcount;
        end
    end

endmodule

`default_nettype wire

// ----- design/wsd_out_buf.sv -----
`default_nettype none

module wsd_out_buf (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_wr,
    input  wsd_pkg::t_out_beat   i_wr_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output wsd_pkg::t_out_beat   o_out_data,
    output wsd_pkg::t_buf_status o_status
);
    import wsd_pkg::*;

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_beat r_out;
    t_out_beat r_skid;
    logic      take;

    assign take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (take) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_wr) begin
                if (!r_out_valid || take)
                    r_out_valid <= 1'b1;
                else
                    r_skid_valid <= 1'b1;
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take)
                r_out <= r_skid;
        end else if (i_wr) begin
            if (!r_out_valid || take)
                r_out <= i_wr_data;
            else
                r_skid <= i_wr_data;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;
    assign o_status.out_full  = r_out_valid;
    assign o_status.skid_full = r_skid_valid;

endmodule

`default_nettype wire
